// ----- design/tpcc_pkg.sv -----
// Shared types, widths and constants of the two-pin component classifier.
package tpcc_pkg;

  // Field widths.
  localparam int PIN_W      = 2;
  localparam int CODE_W     = 12;
  localparam int TCH_W      = 16;
  localparam int SERIES_W   = 10;
  localparam int VALUE_W    = 22;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Default resolution of the divider ADC.
  localparam int ADC_BITS_DEF = 12;

  // Charge time in us times 1000 over ohms gives nF.
  localparam int CAP_SCALE_W = 10;
  localparam logic [CAP_SCALE_W-1:0] CAP_SCALE = 10'd1000;

  // Dividend width of the shared divider (charge time times the scale).
  localparam int DVD_W = TCH_W + CAP_SCALE_W;

  // Multiplier operand and product widths.
  localparam int MUL_A_W = TCH_W;
  localparam int MUL_B_W = CODE_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Saturation value of part_value.
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Register reset values.
  localparam logic [CODE_W-1:0]   RESIDUAL_RST = 12'd500;
  localparam logic [CODE_W-1:0]   OPEN_RST     = 12'd2400;
  localparam logic [SERIES_W-1:0] SERIES_RST   = 10'd680;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES   = 2'd2;

  // Part kinds as reported on the result channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_CAP   = 2'd1,
    KIND_RES   = 2'd2,
    KIND_DIODE = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_CAP,
    S_DIV_CAP,
    S_WAIT_CAP,
    S_EMIT_CAP,
    S_MUL_VAB,
    S_MUL_VBA,
    S_MUL_RAB,
    S_DIV_RAB,
    S_WAIT_RAB,
    S_MUL_RBA,
    S_DIV_RBA,
    S_WAIT_RBA,
    S_EMIT_OPEN,
    S_EMIT_RD
  } state_t;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MUL_CAP,
    MUL_VAB,
    MUL_VBA,
    MUL_RAB,
    MUL_RBA
  } mul_sel_t;

  // Divisor selection.
  typedef enum logic [1:0] {
    DIV_CAP,
    DIV_RAB,
    DIV_RBA
  } div_sel_t;

  // Destination of a stored intermediate result.
  typedef enum logic [2:0] {
    STO_VAB,
    STO_VBA,
    STO_CAP,
    STO_RAB,
    STO_RBA
  } store_sel_t;

  // Which result is written to the output register.
  typedef enum logic [1:0] {
    EM_CAP,
    EM_OPEN,
    EM_RD
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       div_start;
    div_sel_t   div_sel;
    logic       store_en;
    store_sel_t store_sel;
    logic       emit;
    emit_sel_t  emit_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic latched;
    logic is_cap;
    logic is_open;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- design/two_pin_component_classifier.sv -----
// Two-pin component classifier: top level joining controller and datapath.
//
// An item on the in_ channel carries the measurements of one two-pin test.
// The block answers with at most one item on the out_ channel: part kind,
// value (nF, ohms or mV) and the two pin indices. Both channels use
// valid/ready. Registers are written on cfg_; the user must write them only
// while the block is idle, as the block does not enforce it. One item is
// worked at a time, through a shared 16x12 multiplier and a divider that
// produces one quotient bit per cycle. A capacitor needs one division, an
// open pair none, and a resistor or a diode two. A new item is taken in the
// cycle after the result is loaded into the output register, so items do
// not overlap.
// Once a capacitor, resistor or diode has been reported, further items are
// accepted and dropped and give no result.
// A stalled receiver holds the result in the output register; the block
// then waits with the next result until the register is free.
// Reset (synchronous, active low) clears the detection latch and loads
// the register defaults; no clearing pass is needed.
module two_pin_component_classifier import tpcc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIN_W-1:0]      in_pin_a,
  input  logic [PIN_W-1:0]      in_pin_b,
  input  logic [CODE_W-1:0]     in_residual_code,
  input  logic [TCH_W-1:0]      in_charge_time_us,
  input  logic [CODE_W-1:0]     in_code_ab,
  input  logic [CODE_W-1:0]     in_code_ba,
  input  logic [CODE_W-1:0]     in_supply_mv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_part_kind,
  output logic [VALUE_W-1:0]    out_part_value,
  output logic [PIN_W-1:0]      out_cathode_pin,
  output logic [PIN_W-1:0]      out_anode_pin
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  tpcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic and result register.
  tpcc_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_pin_a          (in_pin_a),
    .in_pin_b          (in_pin_b),
    .in_residual_code  (in_residual_code),
    .in_charge_time_us (in_charge_time_us),
    .in_code_ab        (in_code_ab),
    .in_code_ba        (in_code_ba),
    .in_supply_mv      (in_supply_mv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_part_kind     (out_part_kind),
    .out_part_value    (out_part_value),
    .out_cathode_pin   (out_cathode_pin),
    .out_anode_pin     (out_anode_pin),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ----- design/tpcc_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module tpcc_div import tpcc_pkg::*; #(
  parameter int DVS_W = SERIES_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   shifted;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    ge       = shifted >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? DVS_W'(shifted - {1'b0, dvs_r}) : DVS_W'(shifted);
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the operand registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/tpcc_ctrl.sv -----
// Controller state machine that sequences one classification.
module tpcc_ctrl import tpcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // Once a part is latched, items are taken and dropped.
          state_nxt = sts.latched ? S_IDLE : S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.is_cap ? S_MUL_CAP : S_MUL_VAB;
      end
      S_MUL_CAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CAP;
        state_nxt   = S_DIV_CAP;
      end
      S_DIV_CAP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CAP;
        state_nxt     = S_WAIT_CAP;
      end
      S_WAIT_CAP: begin
        if (sts.div_done) begin
          cmd.store_en  = 1'b1;
          cmd.store_sel = STO_CAP;
          state_nxt     = S_EMIT_CAP;
        end
      end
      S_EMIT_CAP: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_CAP;
          state_nxt    = S_IDLE;
        end
      end
      S_MUL_VAB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VAB;
        state_nxt   = S_MUL_VBA;
      end
      S_MUL_VBA: begin
        cmd.store_en  = 1'b1;
        cmd.store_sel = STO_VAB;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_VBA;
        state_nxt     = S_MUL_RAB;
      end
      S_MUL_RAB: begin
        cmd.store_en  = 1'b1;
        cmd.store_sel = STO_VBA;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_RAB;
        state_nxt     = S_DIV_RAB;
      end
      S_DIV_RAB: begin
        // Both voltages are known here; an open pair skips the divisions.
        if (sts.is_open) begin
          state_nxt = S_EMIT_OPEN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RAB;
          state_nxt     = S_WAIT_RAB;
        end
      end
      S_WAIT_RAB: begin
        if (sts.div_done) begin
          cmd.store_en  = 1'b1;
          cmd.store_sel = STO_RAB;
          state_nxt     = S_MUL_RBA;
        end
      end
      S_MUL_RBA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RBA;
        state_nxt   = S_DIV_RBA;
      end
      S_DIV_RBA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RBA;
        state_nxt     = S_WAIT_RBA;
      end
      S_WAIT_RBA: begin
        if (sts.div_done) begin
          cmd.store_en  = 1'b1;
          cmd.store_sel = STO_RBA;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_EMIT_OPEN: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_OPEN;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_RD;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tpcc_dp.sv -----
// Datapath: configuration, operand registers, multiplier, divider and result register.
module tpcc_dp import tpcc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [PIN_W-1:0]      in_pin_a,
  input  logic [PIN_W-1:0]      in_pin_b,
  input  logic [CODE_W-1:0]     in_residual_code,
  input  logic [TCH_W-1:0]      in_charge_time_us,
  input  logic [CODE_W-1:0]     in_code_ab,
  input  logic [CODE_W-1:0]     in_code_ba,
  input  logic [CODE_W-1:0]     in_supply_mv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_part_kind,
  output logic [VALUE_W-1:0]    out_part_value,
  output logic [PIN_W-1:0]      out_cathode_pin,
  output logic [PIN_W-1:0]      out_anode_pin,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int FULL_W = ADC_BITS + 1;
  localparam int DVS_W  = (FULL_W > SERIES_W) ? FULL_W : SERIES_W;
  localparam int EXT_W  = (DVS_W > CODE_W) ? DVS_W : CODE_W;
  localparam int V_W    = 2 * CODE_W - ADC_BITS;
  localparam int VC_W   = (V_W > CODE_W) ? V_W : CODE_W;
  localparam logic [EXT_W-1:0] FULL = EXT_W'(64'd1 << ADC_BITS);

  // Configuration registers.
  logic [CODE_W-1:0]   resid_thr_r;
  logic [CODE_W-1:0]   open_thr_r;
  logic [SERIES_W-1:0] series_r;

  // Captured item fields.
  logic [PIN_W-1:0]  pa_r, pb_r;
  logic [CODE_W-1:0] resid_r, cab_r, cba_r, sup_r;
  logic [TCH_W-1:0]  tch_r;

  // Intermediate results.
  logic [PROD_W-1:0]  prod_r;
  logic [V_W-1:0]     vab_r, vba_r;
  logic [VALUE_W-1:0] cap_r, rab_r, rba_r;

  // Output register.
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [PIN_W-1:0]   out_cath_r, out_an_r;
  logic               latch_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DVS_W-1:0]   divisor;
  logic [DVD_W-1:0]   quo;
  logic               div_done;
  logic [EXT_W-1:0]   cab_x, cba_x;
  logic               sat_ab, sat_ba;
  logic [VALUE_W:0]   r_sum;
  logic [VALUE_W-1:0] r_diff;
  logic               is_res;
  kind_t              em_kind;
  logic [VALUE_W-1:0] em_value;
  logic [PIN_W-1:0]   em_cath, em_an;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resid_thr_r <= RESIDUAL_RST;
      open_thr_r  <= OPEN_RST;
      series_r    <= SERIES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RESIDUAL: resid_thr_r <= cfg_data;
        CFG_OPEN:     open_thr_r  <= cfg_data;
        CFG_SERIES:   series_r    <= cfg_data[SERIES_W-1:0];
        default:      ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa_r    <= in_pin_a;
      pb_r    <= in_pin_b;
      resid_r <= in_residual_code;
      tch_r   <= in_charge_time_us;
      cab_r   <= in_code_ab;
      cba_r   <= in_code_ba;
      sup_r   <= in_supply_mv;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MUL_CAP: begin
        mul_a = tch_r;
        mul_b = MUL_B_W'(CAP_SCALE);
      end
      MUL_VAB: begin
        mul_a = MUL_A_W'(cab_r);
        mul_b = sup_r;
      end
      MUL_VBA: begin
        mul_a = MUL_A_W'(cba_r);
        mul_b = sup_r;
      end
      MUL_RAB: begin
        mul_a = MUL_A_W'(series_r);
        mul_b = cab_r;
      end
      MUL_RBA: begin
        mul_a = MUL_A_W'(series_r);
        mul_b = cba_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Divisor: the series resistor, or the divider's remaining code span.
  assign cab_x  = EXT_W'(cab_r);
  assign cba_x  = EXT_W'(cba_r);
  assign sat_ab = cab_x >= FULL;
  assign sat_ba = cba_x >= FULL;

  always_comb begin
    case (cmd.div_sel)
      DIV_CAP: divisor = DVS_W'(series_r);
      DIV_RAB: divisor = DVS_W'(FULL - cab_x);
      DIV_RBA: divisor = DVS_W'(FULL - cba_x);
      default: divisor = '0;
    endcase
  end

  // A zero series resistor gives an all-ones quotient, which saturates below.
  tpcc_div #(
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r[DVD_W-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // Store of voltages and quotients; a code at full scale saturates its resistance.
  always_ff @(posedge clk) begin
    if (cmd.store_en) begin
      case (cmd.store_sel)
        STO_VAB: vab_r <= prod_r[ADC_BITS +: V_W];
        STO_VBA: vba_r <= prod_r[ADC_BITS +: V_W];
        STO_CAP: cap_r <= (quo > DVD_W'(VALUE_MAX)) ? VALUE_MAX : quo[VALUE_W-1:0];
        STO_RAB: rab_r <= sat_ab ? VALUE_MAX : quo[VALUE_W-1:0];
        STO_RBA: rba_r <= sat_ba ? VALUE_MAX : quo[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Resistor test: eight times the difference is below the sum.
  assign r_sum  = (VALUE_W+1)'(rab_r) + (VALUE_W+1)'(rba_r);
  assign r_diff = (rab_r > rba_r) ? (rab_r - rba_r) : (rba_r - rab_r);
  assign is_res = {r_diff, 3'b000} < (VALUE_W+3)'(r_sum);

  // Result selection.
  always_comb begin
    em_kind  = KIND_NONE;
    em_value = '0;
    em_cath  = pa_r;
    em_an    = pb_r;
    case (cmd.emit_sel)
      EM_CAP: begin
        em_kind  = KIND_CAP;
        em_value = cap_r;
      end
      EM_OPEN: begin
        em_kind = KIND_NONE;
      end
      EM_RD: begin
        if (is_res) begin
          em_kind  = KIND_RES;
          em_value = r_sum[VALUE_W:1];
        end else if (cab_r > cba_r) begin
          // Lower drop measured from pin b to pin a: pin b is the cathode.
          em_kind  = KIND_DIODE;
          em_value = VALUE_W'(vba_r);
          em_cath  = pb_r;
          em_an    = pa_r;
        end else begin
          em_kind  = KIND_DIODE;
          em_value = VALUE_W'(vab_r);
        end
      end
      default: ;
    endcase
  end

  // Output register and detection latch.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      latch_r     <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
      latch_r     <= latch_r | (em_kind != KIND_NONE);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r  <= em_kind;
      out_value_r <= em_value;
      out_cath_r  <= em_cath;
      out_an_r    <= em_an;
    end
  end

  // Status toward the controller.
  assign sts.latched  = latch_r;
  assign sts.is_cap   = resid_r > resid_thr_r;
  assign sts.is_open  = (VC_W'(vab_r) > VC_W'(open_thr_r)) &&
                        (VC_W'(vba_r) > VC_W'(open_thr_r));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_part_kind   = out_kind_r;
  assign out_part_value  = out_value_r;
  assign out_cathode_pin = out_cath_r;
  assign out_anode_pin   = out_an_r;

endmodule
